// ----- sv/ppid_pkg.sv -----
`timescale 1ns / 1ps

package ppid_pkg;

  localparam int DATA_W  = 32;
  localparam int DT_W    = 24;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int INT_W   = 48;
  localparam int DE_W    = 33;
  localparam int SUM_W   = 62;
  localparam int DIFF_W  = 63;
  localparam int MAG_W   = 61;
  localparam int AMAG_W  = 64;

  localparam logic [MAG_W-1:0] PROD_CAP = {1'b1, {(MAG_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BACK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LOW  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd7;

  typedef logic [2:0] op_t;

  // scaled products, in issue order
  localparam op_t OP_TP = 3'd0;  // e * dt
  localparam op_t OP_P  = 3'd1;  // (e * dt) * Kp
  localparam op_t OP_TI = 3'd2;  // integral * dt
  localparam op_t OP_I  = 3'd3;  // (integral * dt) * Ki
  localparam op_t OP_TD = 3'd4;  // (e - last e) * dt
  localparam op_t OP_D  = 3'd5;  // (...) * Kd
  localparam op_t OP_C  = 3'd6;  // (drive - sum) * Kb
  localparam op_t OP_U  = 3'd7;  // correction * dt

  typedef struct packed {
    logic clear;
    logic capture;
    logic load;
    logic save_tp;
    op_t  op;
    logic mul_lo;
    logic mul_hi;
    logic fin;
    logic acc;
    logic clamp;
    logic diff;
    logic corr;
    logic update;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic deriv_en;
    logic back_en;
  } stat_t;

endpackage

// ----- sv/ppid_ctrl.sv -----
`timescale 1ns / 1ps

module ppid_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_kind,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  ppid_pkg::stat_t  stat,
  output ppid_pkg::cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_MLO   = 4'd2;
  localparam logic [3:0] S_MHI   = 4'd3;
  localparam logic [3:0] S_FIN   = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_CLAMP = 4'd6;
  localparam logic [3:0] S_DIFF  = 4'd7;
  localparam logic [3:0] S_CORR  = 4'd8;
  localparam logic [3:0] S_UPD   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]      state_r, state_nxt;
  ppid_pkg::op_t   op_r, op_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.op    = op_r;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_kind) begin
            cmd.clear = 1'b1;
            state_nxt = S_DONE;
          end else begin
            cmd.capture = 1'b1;
            op_nxt      = ppid_pkg::OP_TP;
            state_nxt   = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.load    = 1'b1;
        cmd.save_tp = (op_r == ppid_pkg::OP_P);
        state_nxt   = S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (op_r inside {ppid_pkg::OP_P, ppid_pkg::OP_I, ppid_pkg::OP_D}) begin
          state_nxt = S_ACC;
        end else begin
          case (op_r)
            ppid_pkg::OP_TP: begin
              op_nxt    = ppid_pkg::OP_P;
              state_nxt = S_LOAD;
            end
            ppid_pkg::OP_TI: begin
              op_nxt    = ppid_pkg::OP_I;
              state_nxt = S_LOAD;
            end
            ppid_pkg::OP_TD: begin
              op_nxt    = ppid_pkg::OP_D;
              state_nxt = S_LOAD;
            end
            ppid_pkg::OP_C: begin
              state_nxt = S_CORR;
            end
            ppid_pkg::OP_U: begin
              state_nxt = S_UPD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        case (op_r)
          ppid_pkg::OP_P: begin
            op_nxt    = ppid_pkg::OP_TI;
            state_nxt = S_LOAD;
          end
          ppid_pkg::OP_I: begin
            if (stat.deriv_en) begin
              op_nxt    = ppid_pkg::OP_TD;
              state_nxt = S_LOAD;
            end else begin
              state_nxt = S_CLAMP;
            end
          end
          default: begin
            state_nxt = S_CLAMP;
          end
        endcase
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = stat.back_en ? S_DIFF : S_UPD;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        op_nxt    = ppid_pkg::OP_C;
        state_nxt = S_LOAD;
      end
      S_CORR: begin
        cmd.corr  = 1'b1;
        op_nxt    = ppid_pkg::OP_U;
        state_nxt = S_LOAD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= ppid_pkg::OP_TP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- sv/ppid_dp.sv -----
`timescale 1ns / 1ps

module ppid_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wen,
  input  logic [ppid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ppid_pkg::DATA_W-1:0]           cfg_wdata,
  input  logic signed [ppid_pkg::DATA_W-1:0]    in_target,
  input  logic signed [ppid_pkg::DATA_W-1:0]    in_feedback,
  input  ppid_pkg::cmd_t                        cmd,
  output ppid_pkg::stat_t                       stat,
  output logic signed [ppid_pkg::DATA_W-1:0]    out_drive,
  output logic                                  out_clamped_high,
  output logic                                  out_clamped_low
);

  localparam int DW = ppid_pkg::DATA_W;

  // configuration
  logic signed [DW-1:0]                  gain_p_r, gain_i_r, gain_d_r, gain_back_r;
  logic [ppid_pkg::DT_W-1:0]             step_time_r;
  logic signed [DW-1:0]                  limit_high_r, limit_low_r;
  logic [ppid_pkg::MODE_W-1:0]           mode_r;

  // controller state
  logic signed [ppid_pkg::INT_W-1:0]     integral_r, integral_nxt;
  logic signed [DW-1:0]                  prev_r;

  // per-word working registers
  logic signed [DW-1:0]                  e_r, e_nxt;
  logic signed [ppid_pkg::DE_W-1:0]      de_r, de_nxt;
  logic signed [ppid_pkg::SUM_W-1:0]     sum_r;
  logic signed [DW-1:0]                  drv_r, drv_nxt;
  logic                                  hi_r, hi_nxt, lo_r, lo_nxt;
  logic signed [ppid_pkg::DIFF_W-1:0]    diff_r;
  logic signed [ppid_pkg::SUM_W-1:0]     corr_r;
  logic [DW-1:0]                         tp_mag_r;
  logic                                  tp_neg_r;

  // shared scaled multiplier
  logic [ppid_pkg::AMAG_W-1:0]           a_mag_r, a_mag_nxt;
  logic                                  a_neg_r, a_neg_nxt;
  logic [DW-1:0]                         b_mag_r, b_mag_nxt;
  logic                                  b_neg_r, b_neg_nxt;
  logic                                  sh24_r, sh24_nxt;
  logic [2*DW-1:0]                       pl_r, ph_r, prod;
  logic [DW-1:0]                         mul_in;
  logic [ppid_pkg::MAG_W-1:0]            mag_r, mag_nxt;
  logic                                  neg_r;

  logic signed [DW-1:0]                  out_drive_r;
  logic                                  out_hi_r, out_lo_r;

  // operand selection
  logic signed [ppid_pkg::DIFF_W-1:0]    src;
  logic [ppid_pkg::DIFF_W-1:0]           src_abs;
  logic                                  use_mag;
  logic signed [DW-1:0]                  b_src;

  logic signed [DW:0]                    err_wide;
  logic [3*DW-1:0]                       full, shifted;
  logic signed [ppid_pkg::SUM_W-1:0]     term, tp_term, delta, integ_wide;
  logic                                  sum_gt, sum_lt, integ_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      gain_back_r  <= '0;
      step_time_r  <= '0;
      limit_high_r <= '0;
      limit_low_r  <= '0;
      mode_r       <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        ppid_pkg::CFG_GAIN_P:     gain_p_r     <= cfg_wdata;
        ppid_pkg::CFG_GAIN_I:     gain_i_r     <= cfg_wdata;
        ppid_pkg::CFG_GAIN_D:     gain_d_r     <= cfg_wdata;
        ppid_pkg::CFG_GAIN_BACK:  gain_back_r  <= cfg_wdata;
        ppid_pkg::CFG_STEP_TIME:  step_time_r  <= cfg_wdata[ppid_pkg::DT_W-1:0];
        ppid_pkg::CFG_LIMIT_HIGH: limit_high_r <= cfg_wdata;
        ppid_pkg::CFG_LIMIT_LOW:  limit_low_r  <= cfg_wdata;
        ppid_pkg::CFG_MODE:       mode_r       <= cfg_wdata[ppid_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign stat.deriv_en = mode_r[0];
  assign stat.back_en  = mode_r[1];

  // error, saturated to 32 bits
  assign err_wide = (DW+1)'(in_target) - (DW+1)'(in_feedback);

  always_comb begin
    if (err_wide[DW] != err_wide[DW-1]) begin
      e_nxt = err_wide[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      e_nxt = err_wide[DW-1:0];
    end
    de_nxt = ppid_pkg::DE_W'(e_nxt) - ppid_pkg::DE_W'(prev_r);
  end

  // operand load: sign-magnitude split
  always_comb begin
    src      = '0;
    use_mag  = 1'b0;
    b_src    = gain_p_r;
    sh24_nxt = 1'b0;
    case (cmd.op)
      ppid_pkg::OP_TP: begin
        src      = ppid_pkg::DIFF_W'(e_r);
        b_src    = DW'(step_time_r);
        sh24_nxt = 1'b1;
      end
      ppid_pkg::OP_P: begin
        use_mag = 1'b1;
        b_src   = gain_p_r;
      end
      ppid_pkg::OP_TI: begin
        src      = ppid_pkg::DIFF_W'(integral_r);
        b_src    = DW'(step_time_r);
        sh24_nxt = 1'b1;
      end
      ppid_pkg::OP_I: begin
        use_mag = 1'b1;
        b_src   = gain_i_r;
      end
      ppid_pkg::OP_TD: begin
        src      = ppid_pkg::DIFF_W'(de_r);
        b_src    = DW'(step_time_r);
        sh24_nxt = 1'b1;
      end
      ppid_pkg::OP_D: begin
        use_mag = 1'b1;
        b_src   = gain_d_r;
      end
      ppid_pkg::OP_C: begin
        src   = diff_r;
        b_src = gain_back_r;
      end
      ppid_pkg::OP_U: begin
        src      = ppid_pkg::DIFF_W'(corr_r);
        b_src    = DW'(step_time_r);
        sh24_nxt = 1'b1;
      end
      default: ;
    endcase
    src_abs   = src[ppid_pkg::DIFF_W-1] ? ppid_pkg::DIFF_W'(-src) : ppid_pkg::DIFF_W'(src);
    a_mag_nxt = use_mag ? ppid_pkg::AMAG_W'(mag_r) : ppid_pkg::AMAG_W'(src_abs);
    a_neg_nxt = use_mag ? neg_r : src[ppid_pkg::DIFF_W-1];
    b_neg_nxt = b_src[DW-1];
    b_mag_nxt = b_src[DW-1] ? DW'(-b_src) : DW'(b_src);
  end

  // one 32x32 partial product per cycle
  assign mul_in = cmd.mul_hi ? a_mag_r[2*DW-1:DW] : a_mag_r[DW-1:0];
  assign prod   = mul_in * b_mag_r;

  // scale, truncate toward zero on the magnitude, cap at 2^60
  assign full    = {ph_r, {DW{1'b0}}} + (3*DW)'(pl_r);
  assign shifted = sh24_r ? (full >> 24) : (full >> 16);
  assign mag_nxt = (|shifted[3*DW-1:ppid_pkg::MAG_W-1]) ? ppid_pkg::PROD_CAP
                                                         : ppid_pkg::MAG_W'(shifted);

  assign term    = neg_r ? -ppid_pkg::SUM_W'(mag_r) : ppid_pkg::SUM_W'(mag_r);
  assign tp_term = tp_neg_r ? -ppid_pkg::SUM_W'(tp_mag_r) : ppid_pkg::SUM_W'(tp_mag_r);

  // output clamp
  assign sum_gt = sum_r > ppid_pkg::SUM_W'(limit_high_r);
  assign sum_lt = sum_r < ppid_pkg::SUM_W'(limit_low_r);

  always_comb begin
    drv_nxt = sum_r[DW-1:0];
    hi_nxt  = 1'b0;
    lo_nxt  = 1'b0;
    if (sum_gt) begin
      drv_nxt = limit_high_r;
      hi_nxt  = 1'b1;
    end else if (sum_lt) begin
      drv_nxt = limit_low_r;
      lo_nxt  = 1'b1;
    end
  end

  // integral update with saturation to 48 bits
  assign integ_en   = mode_r[1] || (!hi_r && !lo_r) || (hi_r && e_r[DW-1]) ||
                      (lo_r && !e_r[DW-1] && (|e_r));
  assign delta      = mode_r[1] ? term : tp_term;
  assign integ_wide = ppid_pkg::SUM_W'(integral_r) + delta;

  always_comb begin
    if (integ_wide[ppid_pkg::SUM_W-1:ppid_pkg::INT_W-1] ==
        {(ppid_pkg::SUM_W-ppid_pkg::INT_W+1){integ_wide[ppid_pkg::SUM_W-1]}}) begin
      integral_nxt = integ_wide[ppid_pkg::INT_W-1:0];
    end else if (integ_wide[ppid_pkg::SUM_W-1]) begin
      integral_nxt = {1'b1, {(ppid_pkg::INT_W-1){1'b0}}};
    end else begin
      integral_nxt = {1'b0, {(ppid_pkg::INT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      prev_r     <= '0;
    end else if (cmd.clear) begin
      integral_r <= '0;
      prev_r     <= '0;
    end else if (cmd.update) begin
      if (integ_en) begin
        integral_r <= integral_nxt;
      end
      prev_r <= e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      e_r   <= e_nxt;
      de_r  <= de_nxt;
      sum_r <= '0;
    end
    if (cmd.load) begin
      a_mag_r <= a_mag_nxt;
      a_neg_r <= a_neg_nxt;
      b_mag_r <= b_mag_nxt;
      b_neg_r <= b_neg_nxt;
      sh24_r  <= sh24_nxt;
    end
    if (cmd.save_tp) begin
      tp_mag_r <= mag_r[DW-1:0];
      tp_neg_r <= neg_r;
    end
    if (cmd.mul_lo) begin
      pl_r <= prod;
    end
    if (cmd.mul_hi) begin
      ph_r <= prod;
    end
    if (cmd.fin) begin
      mag_r <= mag_nxt;
      neg_r <= a_neg_r ^ b_neg_r;
    end
    if (cmd.acc) begin
      sum_r <= sum_r + term;
    end
    if (cmd.clear) begin
      drv_r <= '0;
      hi_r  <= 1'b0;
      lo_r  <= 1'b0;
    end else if (cmd.clamp) begin
      drv_r <= drv_nxt;
      hi_r  <= hi_nxt;
      lo_r  <= lo_nxt;
    end
    if (cmd.diff) begin
      diff_r <= ppid_pkg::DIFF_W'(drv_r) - ppid_pkg::DIFF_W'(sum_r);
    end
    if (cmd.corr) begin
      corr_r <= term + ppid_pkg::SUM_W'(e_r);
    end
    if (cmd.out_load) begin
      out_drive_r <= drv_r;
      out_hi_r    <= hi_r;
      out_lo_r    <= lo_r;
    end
  end

  assign out_drive        = out_drive_r;
  assign out_clamped_high = out_hi_r;
  assign out_clamped_low  = out_lo_r;

endmodule

// ----- sv/positional_pid_controller.sv -----
// Positional PID step through one shared 32x32 multiplier; each scaled product takes
// a load, a low and a high partial product, then a finish. A run word sums the P, I and,
// with derivative on, D terms, clamps the drive and updates the integral, through the
// back-calculation correction when on. A clear word zeroes integral, last error, drive.
// The result is registered, so the next word is taken while it waits.
// rst_n is synchronous: config registers, error integral and last error reset to zero.
`timescale 1ns / 1ps

module positional_pid_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [2*ppid_pkg::DATA_W-1:0]       in_tdata,   // target, feedback
  input  logic                                in_tuser,   // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ppid_pkg::DATA_W-1:0]         out_tdata,  // drive
  output logic [1:0]                          out_tuser,  // clamped_high, clamped_low
  input  logic                                cfg_wen,
  input  logic [ppid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppid_pkg::DATA_W-1:0]         cfg_wdata
);

  localparam int DW = ppid_pkg::DATA_W;

  ppid_pkg::cmd_t   ctrl_cmd;
  ppid_pkg::stat_t  dp_stat;
  logic signed [DW-1:0] drive;
  logic                 clamped_high, clamped_low;

  ppid_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (dp_stat),
    .cmd        (ctrl_cmd)
  );

  ppid_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wen          (cfg_wen),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_target        (in_tdata[DW-1:0]),
    .in_feedback      (in_tdata[2*DW-1:DW]),
    .cmd              (ctrl_cmd),
    .stat             (dp_stat),
    .out_drive        (drive),
    .out_clamped_high (clamped_high),
    .out_clamped_low  (clamped_low)
  );

  assign out_tdata = drive;
  assign out_tuser = {clamped_low, clamped_high};

`ifndef SYNTHESIS
  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is in progress");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("pending result overwritten");

  a_single_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl_cmd.clear, ctrl_cmd.capture, ctrl_cmd.load, ctrl_cmd.mul_lo,
              ctrl_cmd.mul_hi, ctrl_cmd.fin, ctrl_cmd.acc, ctrl_cmd.clamp,
              ctrl_cmd.diff, ctrl_cmd.corr, ctrl_cmd.update, ctrl_cmd.out_load}))
    else $error("more than one datapath action in a cycle");

  a_clamp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("both clamp flags set");
`endif

endmodule
